>>> sv/sxd_pkg.sv
// shared types and constants for the section xor decrypt and checksum block
`timescale 1ns / 1ps
`default_nettype none

package sxd_pkg;

	localparam int SEED_W = 16;
	localparam int SUM_W  = 32;
	localparam int KEY_W  = 32;
	localparam int POS_W  = 4;
	localparam int BYTE_W = 8;

	localparam logic [0:0] CFG_KEY_SEED     = 1'd0;
	localparam logic [0:0] CFG_EXPECTED_SUM = 1'd1;

	localparam logic [POS_W-1:0] POS_LAST = 4'hf;

	typedef struct packed {
		logic [BYTE_W-1:0] cipher_byte;
		logic              first_byte;
		logic              last_byte;
	} beat_in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] plain_byte;
		logic              end_of_section;
		logic              sum_matches;
		logic [SUM_W-1:0]  running_sum;
	} beat_out_t;

endpackage

`default_nettype wire

>>> sv/sxd_core.sv
// keystream, position and checksum state with the per-byte decrypt logic
`timescale 1ns / 1ps
`default_nettype none

module sxd_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      advance,
	input  wire sxd_pkg::beat_in_t         beat,
	input  wire logic [sxd_pkg::SEED_W-1:0] key_seed,
	input  wire logic [sxd_pkg::SUM_W-1:0]  expected_sum,
	output sxd_pkg::beat_out_t             result
);
	import sxd_pkg::*;

	logic [KEY_W-1:0]  key_q;
	logic [POS_W-1:0]  pos_q;
	logic [SUM_W-1:0]  sum_q;

	logic [KEY_W-1:0]  key_cur;
	logic [POS_W-1:0]  pos_cur;
	logic [SUM_W-1:0]  sum_cur;
	logic [KEY_W-1:0]  key_next;
	logic [POS_W-1:0]  pos_next;
	logic [SUM_W-1:0]  sum_next;
	logic [BYTE_W-1:0] plain;

	always_comb begin
		key_cur = beat.first_byte ? {key_seed, key_seed} : key_q;
		pos_cur = beat.first_byte ? '0 : pos_q;
		sum_cur = beat.first_byte ? '0 : sum_q;

		plain = beat.cipher_byte ^ key_cur[23:16];

		key_next = {key_cur[KEY_W-2:0], 1'b0};
		if (pos_cur == POS_LAST) begin
			key_next = key_next | {{(KEY_W-SEED_W){1'b0}}, key_seed};
		end
		pos_next = pos_cur + 1'b1;
		sum_next = {sum_cur[SUM_W-2:0], 1'b0} + {{(SUM_W-BYTE_W){1'b0}}, plain};

		result.plain_byte     = plain;
		result.end_of_section = beat.last_byte;
		result.sum_matches    = beat.last_byte && (sum_next == expected_sum);
		result.running_sum    = sum_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			pos_q <= '0;
			sum_q <= '0;
		end else if (advance) begin
			key_q <= key_next;
			pos_q <= pos_next;
			sum_q <= sum_next;
		end
	end

endmodule

`default_nettype wire

>>> sv/section_xor_decrypt_checksum.sv
// top level: config registers, input and result stages around the decrypt core
`timescale 1ns / 1ps
`default_nettype none

// Decrypts a section one byte per beat and keeps its running checksum. Each
// byte passes through the input register, then the result register, and a
// new byte is accepted every cycle while out_ready does not stall the output;
// the key shift and the checksum double-and-add sit between those two
// registers. A beat marked first_byte reloads the key from key_seed and
// clears the checksum; sum_matches is reported on the beat marked last_byte.
// Write the config registers only while no beat is in flight.
module section_xor_decrypt_checksum (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  cipher_byte,
	input  wire logic        first_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       plain_byte,
	output logic             end_of_section,
	output logic             sum_matches,
	output logic [31:0]      running_sum
);
	import sxd_pkg::*;

	logic [SEED_W-1:0] seed_q;
	logic [SUM_W-1:0]  expected_q;

	logic      valid_s1;
	beat_in_t  beat_s1;
	logic      valid_s2;
	beat_out_t result_s2;
	beat_out_t result;
	logic      advance;
	logic      s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q     <= '0;
			expected_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KEY_SEED:     seed_q     <= cfg_data[SEED_W-1:0];
				CFG_EXPECTED_SUM: expected_q <= cfg_data[SUM_W-1:0];
				default: ;
			endcase
		end
	end

	assign s2_free  = !valid_s2 || out_ready;
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1.cipher_byte <= cipher_byte;
			beat_s1.first_byte  <= first_byte;
			beat_s1.last_byte   <= last_byte;
		end
	end

	sxd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.beat         (beat_s1),
		.key_seed     (seed_q),
		.expected_sum (expected_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign plain_byte     = result_s2.plain_byte;
	assign end_of_section = result_s2.end_of_section;
	assign sum_matches    = result_s2.sum_matches;
	assign running_sum    = result_s2.running_sum;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted beat lost from input stage");

	a_match_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sum_matches |-> end_of_section)
		else $error("sum match flagged on a non-final beat");

	a_advance_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced beat lost from result stage");
`endif

endmodule

`default_nettype wire
